@@ sv/lrgd_pkg.sv @@
// Package with the types and constants of the linear regression gradient descent core.
`timescale 1ns / 1ps
`default_nettype none

package lrgd_pkg;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int EPOCH_W    = 20;
   localparam int COEF_W     = 48;

   localparam logic [CSR_ADDR_W-1:0] CSR_SLOPE_RATE     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INTERCEPT_RATE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_EPOCH_COUNT    = 2'd2;

   localparam logic [31:0]      RATE_RESET  = 32'd42950;
   localparam logic [EPOCH_W-1:0] EPOCH_RESET = 20'd30000;

   localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN48 = 64'shFFFF_8000_0000_0000;

   typedef struct packed {
      logic              ovf;
      logic signed [63:0] val;
   } sat_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_MEAN_X,
      ST_MEAN_Y,
      ST_CEN_INIT,
      ST_CEN_RD,
      ST_CEN_WR,
      ST_EPOCH_CHK,
      ST_EP_RD,
      ST_EP_LATCH,
      ST_EP_PRED,
      ST_EP_ERR,
      ST_EP_MUL2,
      ST_EP_ACC,
      ST_GA,
      ST_GB,
      ST_UPD_START,
      ST_UPD_A,
      ST_UPD_B,
      ST_FINAL,
      ST_FINAL_END,
      ST_EMIT,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_SUM,
      ST_MUL_FIN,
      ST_DIV,
      ST_DIV_FIN
   } state_type;

endpackage

`default_nettype wire

@@ sv/linear_regression_gradient_descent_core.sv @@
// Linear regression core: sample memories, shared multiplier and divider, training sequencer.
//
// Requests carry one (x, y) sample each, signed Q16.16, on req_tdata; req_tlast marks the
// final sample of a data set. Samples load at one per cycle into the x and y memories;
// beyond MAX_SAMPLES they are dropped and samples_dropped is raised.
// After the final sample the core stops taking requests and trains: a summing pass,
// two divisions for the means, a centring pass, then per epoch a pass in which each
// sample goes through the shared 32x32 multiplier twice, ending with two bit-serial
// 64-bit divisions and two rate products, and a final product for the intercept.
// One response then carries slope and intercept (Q24.24 by default) plus the two flags.
// The response sits in an output register: the core takes the next data set while it
// waits, and only stalls before writing the next response if rsp_tready is still low.
// The csr_ port writes slope_rate, intercept_rate and epoch_count; write it only when idle.
// Reset restores the register defaults, empties the memories' fill count and clears the
// flags; the memories themselves are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module linear_regression_gradient_descent_core #(
   parameter int MAX_SAMPLES    = 1024,
   parameter int COEF_FRAC_BITS = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [63:0]                       req_tdata,  // x_sample, y_sample
   input  wire logic                              req_tlast,  // last_sample
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [95:0]                            rsp_tdata,  // slope, intercept
   output logic [1:0]                             rsp_tuser,  // saturated, samples_dropped
   input  wire logic                              csr_we,
   input  wire logic [lrgd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [lrgd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lrgd_pkg::*;

   localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int SHL = (COEF_FRAC_BITS >= 16) ? COEF_FRAC_BITS - 16 : 0;
   localparam int SHR = (COEF_FRAC_BITS < 16) ? 16 - COEF_FRAC_BITS : 0;

   function automatic sat_type sadd64(input logic signed [63:0] a, input logic signed [63:0] b);
      logic signed [64:0] s;
      sat_type r;
      s = {a[63], a} + {b[63], b};
      r.ovf = s[64] ^ s[63];
      r.val = r.ovf ? (s[64] ? MIN64 : MAX64) : s[63:0];
      return r;
   endfunction

   function automatic sat_type ssub64(input logic signed [63:0] a, input logic signed [63:0] b);
      logic signed [64:0] s;
      sat_type r;
      s = {a[63], a} - {b[63], b};
      r.ovf = s[64] ^ s[63];
      r.val = r.ovf ? (s[64] ? MIN64 : MAX64) : s[63:0];
      return r;
   endfunction

   function automatic sat_type clamp48(input logic signed [63:0] a);
      sat_type r;
      r.ovf = (a > MAX48) || (a < MIN48);
      r.val = (a > MAX48) ? MAX48 : ((a < MIN48) ? MIN48 : a);
      return r;
   endfunction

   // Q16.16 to COEF_FRAC_BITS fraction bits; a right shift truncates toward zero.
   function automatic logic signed [63:0] align_f(input logic signed [63:0] v);
      logic signed [63:0] bias;
      bias = v[63] ? ((64'sd1 <<< SHR) - 64'sd1) : 64'sd0;
      return ((v <<< SHL) + bias) >>> SHR;
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

   // Configuration registers
   logic [31:0]        slope_rate_ff, intercept_rate_ff;
   logic [EPOCH_W-1:0] epoch_count_ff;

   // Sequencer and datapath registers
   state_type state_ff, state_in, ret_ff, ret_in;
   logic [CW-1:0]      count_ff, count_in, i_ff, i_in;
   logic [EPOCH_W-1:0] ep_ff, ep_in;
   logic               sat_ff, sat_in, drop_ff, drop_in;
   logic signed [63:0] sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic signed [31:0] mean_x_ff, mean_x_in, u_ff, u_in;
   logic signed [63:0] yal_ff, yal_in, err_ff, err_in;
   logic signed [63:0] ga_ff, ga_in, gb_ff, gb_in;
   logic signed [COEF_W-1:0] slope_ff, slope_in, icpt_ff, icpt_in, icpt_out_ff, icpt_out_in;

   // Multiplier: magnitude operands, two 32x32 partial products
   logic [63:0]  mul_ma_ff, mul_ma_in, p0_ff, p0_in, p1_ff, p1_in;
   logic [31:0]  mul_mb_ff, mul_mb_in;
   logic         mul_neg_ff, mul_neg_in, mul_s32_ff, mul_s32_in;
   logic [95:0]  full_ff, full_in;
   logic signed [63:0] mul_r_ff, mul_r_in;

   // Divider: restoring, one quotient bit a cycle, divisor is the sample count
   logic [63:0]  div_num_ff, div_num_in;
   logic [CW-1:0] div_rem_ff, div_rem_in;
   logic [5:0]   div_cnt_ff, div_cnt_in;
   logic         div_neg_ff, div_neg_in;
   logic signed [63:0] div_q_ff, div_q_in;

   // Response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;

   // Memories
   logic signed [31:0] x_mem [MAX_SAMPLES];
   logic signed [31:0] y_mem [MAX_SAMPLES];
   logic signed [31:0] x_rd_ff, y_rd_ff;
   logic               x_we, y_we;
   logic [AW-1:0]      x_waddr;
   logic signed [31:0] x_wdata;

   logic               req_fire, full, i_last, rsp_free;
   logic signed [32:0] cen_diff;
   logic signed [31:0] cen_val;

   // Launch requests to the shared units
   logic               mul_go, mul_s32_sel, div_go;
   logic signed [63:0] mul_a, div_a;
   logic signed [32:0] mul_b;
   state_type          go_ret;

   assign req_fire = req_tvalid && req_tready;
   assign full     = (count_ff == CW'(MAX_SAMPLES));
   assign i_last   = ((i_ff + CW'(1)) == count_ff);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign cen_diff = {x_rd_ff[31], x_rd_ff} - {mean_x_ff[31], mean_x_ff};
   assign cen_val  = (cen_diff[32] != cen_diff[31]) ?
                     (cen_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : cen_diff[31:0];

   always_ff @(posedge clock) begin
      if (x_we) begin
         x_mem[x_waddr] <= x_wdata;
      end
      if (y_we) begin
         y_mem[count_ff[AW-1:0]] <= req_tdata[63:32];
      end
      x_rd_ff <= x_mem[i_ff[AW-1:0]];
      y_rd_ff <= y_mem[i_ff[AW-1:0]];
   end

   // Handshake and memory control
   always_comb begin
      req_tready = (state_ff == ST_LOAD);
      y_we       = req_fire && !full;
      x_we       = y_we || (state_ff == ST_CEN_WR);
      x_waddr    = (state_ff == ST_LOAD) ? count_ff[AW-1:0] : i_ff[AW-1:0];
      x_wdata    = (state_ff == ST_LOAD) ? req_tdata[31:0] : cen_val;
   end

   // Which unit is launched, with what operands and where it returns
   always_comb begin
      mul_go      = 1'b0;
      mul_s32_sel = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      div_go      = 1'b0;
      div_a       = '0;
      go_ret      = ST_LOAD;
      case (state_ff)
         ST_MEAN_X: begin
            div_go = 1'b1;
            div_a  = sum_a_ff;
            go_ret = ST_MEAN_Y;
         end
         ST_MEAN_Y: begin
            div_go = 1'b1;
            div_a  = sum_b_ff;
            go_ret = ST_CEN_INIT;
         end
         ST_EP_LATCH: begin
            mul_go = 1'b1;
            mul_a  = 64'(slope_ff);
            mul_b  = 33'(x_rd_ff);
            go_ret = ST_EP_PRED;
         end
         ST_EP_MUL2: begin
            mul_go = 1'b1;
            mul_a  = err_ff;
            mul_b  = 33'(u_ff);
            go_ret = ST_EP_ACC;
         end
         ST_GA: begin
            div_go = 1'b1;
            div_a  = sadd64(sum_a_ff, sum_a_ff).val;
            go_ret = ST_GB;
         end
         ST_GB: begin
            div_go = 1'b1;
            div_a  = sadd64(sum_b_ff, sum_b_ff).val;
            go_ret = ST_UPD_START;
         end
         ST_UPD_START: begin
            mul_go      = 1'b1;
            mul_s32_sel = 1'b1;
            mul_a       = ga_ff;
            mul_b       = {1'b0, slope_rate_ff};
            go_ret      = ST_UPD_A;
         end
         ST_UPD_A: begin
            mul_go      = 1'b1;
            mul_s32_sel = 1'b1;
            mul_a       = gb_ff;
            mul_b       = {1'b0, intercept_rate_ff};
            go_ret      = ST_UPD_B;
         end
         ST_FINAL: begin
            mul_go = 1'b1;
            mul_a  = 64'(slope_ff);
            mul_b  = 33'(mean_x_ff);
            go_ret = ST_FINAL_END;
         end
         default: begin
            mul_go = 1'b0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:      if (req_fire && req_tlast) state_in = ST_SUM_RD;
         ST_SUM_RD:    state_in = ST_SUM_ACC;
         ST_SUM_ACC:   state_in = i_last ? ST_MEAN_X : ST_SUM_RD;
         ST_CEN_INIT:  state_in = ST_CEN_RD;
         ST_CEN_RD:    state_in = ST_CEN_WR;
         ST_CEN_WR:    state_in = i_last ? ST_EPOCH_CHK : ST_CEN_RD;
         ST_EPOCH_CHK: state_in = (ep_ff == epoch_count_ff) ? ST_FINAL : ST_EP_RD;
         ST_EP_RD:     state_in = ST_EP_LATCH;
         ST_EP_PRED:   state_in = ST_EP_ERR;
         ST_EP_ERR:    state_in = ST_EP_MUL2;
         ST_EP_ACC:    state_in = i_last ? ST_GA : ST_EP_RD;
         ST_UPD_B:     state_in = ST_EPOCH_CHK;
         ST_FINAL_END: state_in = ST_EMIT;
         ST_EMIT:      if (rsp_free) state_in = ST_LOAD;
         ST_MUL_LO:    state_in = ST_MUL_HI;
         ST_MUL_HI:    state_in = ST_MUL_SUM;
         ST_MUL_SUM:   state_in = ST_MUL_FIN;
         ST_MUL_FIN:   state_in = ret_ff;
         ST_DIV:       if (div_cnt_ff == 6'd63) state_in = ST_DIV_FIN;
         ST_DIV_FIN:   state_in = ret_ff;
         default:      state_in = state_ff;
      endcase
      if (mul_go) begin
         state_in = ST_MUL_LO;
      end
      if (div_go) begin
         state_in = ST_DIV;
      end
   end

   // Datapath next values
   always_comb begin
      sat_type            t1, t2;
      logic [CW:0]        rem_sh;
      logic [95:0]        shifted;
      logic [63:0]        lim, rlo;
      logic               movf;

      count_in     = count_ff;
      i_in         = i_ff;
      ep_in        = ep_ff;
      sat_in       = sat_ff;
      drop_in      = drop_ff;
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      mean_x_in    = mean_x_ff;
      u_in         = u_ff;
      yal_in       = yal_ff;
      err_in       = err_ff;
      ga_in        = ga_ff;
      gb_in        = gb_ff;
      slope_in     = slope_ff;
      icpt_in      = icpt_ff;
      icpt_out_in  = icpt_out_ff;
      ret_in       = ret_ff;
      mul_ma_in    = mul_ma_ff;
      mul_mb_in    = mul_mb_ff;
      mul_neg_in   = mul_neg_ff;
      mul_s32_in   = mul_s32_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      full_in      = full_ff;
      mul_r_in     = mul_r_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_cnt_in   = div_cnt_ff;
      div_neg_in   = div_neg_ff;
      div_q_in     = div_q_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      t1           = '0;
      t2           = '0;
      rem_sh       = '0;
      shifted      = '0;
      lim          = '0;
      rlo          = '0;
      movf         = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
               if (req_tlast) begin
                  i_in     = '0;
                  sum_a_in = '0;
                  sum_b_in = '0;
               end
            end
         end
         ST_SUM_ACC: begin
            sum_a_in = sum_a_ff + 64'(x_rd_ff);
            sum_b_in = sum_b_ff + 64'(y_rd_ff);
            i_in     = i_ff + CW'(1);
         end
         ST_MEAN_Y: begin
            mean_x_in = div_q_ff[31:0];
         end
         ST_CEN_INIT: begin
            t1       = clamp48(align_f(div_q_ff));
            icpt_in  = t1.val[COEF_W-1:0];
            sat_in   = sat_ff | t1.ovf;
            slope_in = '0;
            i_in     = '0;
            ep_in    = '0;
         end
         ST_CEN_WR: begin
            sat_in = sat_ff | (cen_diff[32] != cen_diff[31]);
            i_in   = i_ff + CW'(1);
         end
         ST_EPOCH_CHK: begin
            i_in     = '0;
            sum_a_in = '0;
            sum_b_in = '0;
         end
         ST_EP_LATCH: begin
            u_in   = x_rd_ff;
            yal_in = align_f(64'(y_rd_ff));
         end
         ST_EP_PRED: begin
            t1     = sadd64(mul_r_ff, 64'(icpt_ff));
            err_in = t1.val;
            sat_in = sat_ff | t1.ovf;
         end
         ST_EP_ERR: begin
            t1     = ssub64(err_ff, yal_ff);
            err_in = t1.val;
            sat_in = sat_ff | t1.ovf;
         end
         ST_EP_ACC: begin
            t1       = sadd64(sum_a_ff, mul_r_ff);
            t2       = sadd64(sum_b_ff, err_ff);
            sum_a_in = t1.val;
            sum_b_in = t2.val;
            sat_in   = sat_ff | t1.ovf | t2.ovf;
            i_in     = i_ff + CW'(1);
         end
         ST_GA: begin
            sat_in = sat_ff | sadd64(sum_a_ff, sum_a_ff).ovf;
         end
         ST_GB: begin
            ga_in  = div_q_ff;
            sat_in = sat_ff | sadd64(sum_b_ff, sum_b_ff).ovf;
         end
         ST_UPD_START: begin
            gb_in = div_q_ff;
         end
         ST_UPD_A: begin
            t1       = ssub64(64'(slope_ff), mul_r_ff);
            t2       = clamp48(t1.val);
            slope_in = t2.val[COEF_W-1:0];
            sat_in   = sat_ff | t1.ovf | t2.ovf;
         end
         ST_UPD_B: begin
            t1      = ssub64(64'(icpt_ff), mul_r_ff);
            t2      = clamp48(t1.val);
            icpt_in = t2.val[COEF_W-1:0];
            sat_in  = sat_ff | t1.ovf | t2.ovf;
            ep_in   = ep_ff + EPOCH_W'(1);
         end
         ST_FINAL_END: begin
            t1          = ssub64(64'(icpt_ff), mul_r_ff);
            t2          = clamp48(t1.val);
            icpt_out_in = t2.val[COEF_W-1:0];
            sat_in      = sat_ff | t1.ovf | t2.ovf;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {icpt_out_ff, slope_ff};
               rsp_user_in  = {drop_ff, sat_ff};
               count_in     = '0;
               sat_in       = 1'b0;
               drop_in      = 1'b0;
            end
         end
         ST_MUL_LO: begin
            p0_in = 64'(mul_ma_ff[31:0]) * 64'(mul_mb_ff);
         end
         ST_MUL_HI: begin
            p1_in = 64'(mul_ma_ff[63:32]) * 64'(mul_mb_ff);
         end
         ST_MUL_SUM: begin
            full_in = {32'd0, p0_ff} + {p1_ff, 32'd0};
         end
         ST_MUL_FIN: begin
            shifted = mul_s32_ff ? (full_ff >> 32) : (full_ff >> 16);
            lim     = mul_neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            movf    = (shifted[95:64] != 32'd0) || (shifted[63:0] > lim);
            rlo     = movf ? lim : shifted[63:0];
            mul_r_in = mul_neg_ff ? -rlo : rlo;
            sat_in  = sat_ff | movf;
         end
         ST_DIV: begin
            rem_sh     = {div_rem_ff, div_num_ff[63]};
            if (rem_sh >= {1'b0, count_ff}) begin
               div_rem_in = CW'(rem_sh - {1'b0, count_ff});
               div_num_in = {div_num_ff[62:0], 1'b1};
            end else begin
               div_rem_in = rem_sh[CW-1:0];
               div_num_in = {div_num_ff[62:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 6'd1;
         end
         ST_DIV_FIN: begin
            if (count_ff == '0) begin
               div_q_in = '0;
            end else begin
               div_q_in = div_neg_ff ? -div_num_ff : div_num_ff;
            end
         end
         default: begin
            sat_in = sat_ff;
         end
      endcase

      if (mul_go) begin
         mul_ma_in  = mag64(mul_a);
         mul_mb_in  = mul_b[32] ? 32'(-mul_b) : mul_b[31:0];
         mul_neg_in = mul_a[63] ^ mul_b[32];
         mul_s32_in = mul_s32_sel;
         ret_in     = go_ret;
      end
      if (div_go) begin
         div_num_in = mag64(div_a);
         div_neg_in = div_a[63];
         div_rem_in = '0;
         div_cnt_in = '0;
         ret_in     = go_ret;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_LOAD;
         ret_ff            <= ST_LOAD;
         count_ff          <= '0;
         sat_ff            <= 1'b0;
         drop_ff           <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         slope_rate_ff     <= RATE_RESET;
         intercept_rate_ff <= RATE_RESET;
         epoch_count_ff    <= EPOCH_RESET;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         count_ff     <= count_in;
         sat_ff       <= sat_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_SLOPE_RATE:     slope_rate_ff     <= csr_wdata;
               CSR_INTERCEPT_RATE: intercept_rate_ff <= csr_wdata;
               CSR_EPOCH_COUNT:    epoch_count_ff    <= csr_wdata[EPOCH_W-1:0];
               default:            epoch_count_ff    <= epoch_count_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      ep_ff       <= ep_in;
      sum_a_ff    <= sum_a_in;
      sum_b_ff    <= sum_b_in;
      mean_x_ff   <= mean_x_in;
      u_ff        <= u_in;
      yal_ff      <= yal_in;
      err_ff      <= err_in;
      ga_ff       <= ga_in;
      gb_ff       <= gb_in;
      slope_ff    <= slope_in;
      icpt_ff     <= icpt_in;
      icpt_out_ff <= icpt_out_in;
      mul_ma_ff   <= mul_ma_in;
      mul_mb_ff   <= mul_mb_in;
      mul_neg_ff  <= mul_neg_in;
      mul_s32_ff  <= mul_s32_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      full_ff     <= full_in;
      mul_r_ff    <= mul_r_in;
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_cnt_ff  <= div_cnt_in;
      div_neg_ff  <= div_neg_in;
      div_q_ff    <= div_q_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SAMPLES))
      else $error("sample count beyond capacity");

   a_last_stops_load: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> !req_tready)
      else $error("requests still taken after the final sample");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_free) |=> (rsp_tvalid && count_ff == '0 && !sat_ff))
      else $error("response not written or data set state not cleared");

   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_FIN) |-> $past(state_ff == ST_DIV))
      else $error("divider finished without iterating");
`endif

endmodule

`default_nettype wire

@@ tb/lrgd_checker.sv @@
// Checker for the regression core: mirrors its training arithmetic and compares every response.
`timescale 1ns / 1ps
`default_nettype none

module lrgd_checker
   import lrgd_pkg::*;
#(
   parameter int MAX_SAMPLES = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [63:0]  req_tdata,
   input  wire logic         req_tlast,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [95:0]  rsp_tdata,
   input  wire logic [1:0]   rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                fit_errors,
   output int                fits_pending,
   output int                fits_checked
);

   typedef struct {
      logic [47:0] slope;
      logic [47:0] intercept;
      logic        saturated;
      logic        dropped;
   } fit_type;

   fit_type     fit_q[$];
   logic [31:0] slope_rate, intercept_rate;
   logic [EPOCH_W-1:0] epoch_total;
   int          x_mem[MAX_SAMPLES];
   int          y_mem[MAX_SAMPLES];
   int          fill;
   logic        sat_seen, drop_seen;
   longint      slope_c, icpt_c;

   function automatic longint clamp_to(longint v, int w);
      longint hi, lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         sat_seen = 1'b1;
         return hi;
      end
      if (v < lo) begin
         sat_seen = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic longint clamp65(logic signed [64:0] s);
      if (s > 65'sd9223372036854775807) begin
         sat_seen = 1'b1;
         return 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      if (s < -65'sd9223372036854775808) begin
         sat_seen = 1'b1;
         return 64'sh8000_0000_0000_0000;
      end
      return longint'(s[63:0]);
   endfunction

   function automatic longint add_sat(longint a, longint b);
      logic signed [64:0] s;
      s = a;
      s = s + b;
      return clamp65(s);
   endfunction

   function automatic longint sub_sat(longint a, longint b);
      logic signed [64:0] s;
      s = a;
      s = s - b;
      return clamp65(s);
   endfunction

   // Exact product, magnitude shifted right, saturated to 64 bit signed.
   function automatic longint mul_shift(longint a, longint b, int s);
      logic         neg;
      logic [63:0]  ua, ub, lim;
      logic [127:0] p, r;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? 64'(-a) : 64'(a);
      ub = (b < 0) ? 64'(-b) : 64'(b);
      p = {64'b0, ua} * {64'b0, ub};
      r = p >> s;
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (r > {64'b0, lim}) begin
         sat_seen = 1'b1;
         r = {64'b0, lim};
      end
      return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
   endfunction

   function automatic longint div_count(longint v, int n);
      return (n != 0) ? v / longint'(n) : 0;
   endfunction

   function automatic void descend_once(int n);
      longint sum_eu, sum_e, u, pred, err, ga, gb;
      sum_eu = 0;
      sum_e = 0;
      for (int i = 0; i < n; i++) begin
         u = x_mem[i];
         pred = add_sat(mul_shift(slope_c, u, 16), icpt_c);
         err = sub_sat(pred, longint'(y_mem[i]) * 256);
         sum_eu = add_sat(sum_eu, mul_shift(err, u, 16));
         sum_e = add_sat(sum_e, err);
      end
      ga = div_count(add_sat(sum_eu, sum_eu), n);
      gb = div_count(add_sat(sum_e, sum_e), n);
      slope_c = clamp_to(sub_sat(slope_c, mul_shift(ga, longint'(slope_rate), 32)), COEF_W);
      icpt_c = clamp_to(sub_sat(icpt_c, mul_shift(gb, longint'(intercept_rate), 32)), COEF_W);
   endfunction

   function automatic fit_type fit_line();
      longint  sx, sy, mean_x, mean_y, icpt;
      fit_type f;
      sx = 0;
      sy = 0;
      for (int i = 0; i < fill; i++) begin
         sx += x_mem[i];
         sy += y_mem[i];
      end
      mean_x = clamp_to(div_count(sx, fill), 32);
      mean_y = div_count(sy, fill);
      for (int i = 0; i < fill; i++)
         x_mem[i] = int'(clamp_to(longint'(x_mem[i]) - mean_x, 32));
      slope_c = 0;
      icpt_c = clamp_to(mean_y * 256, COEF_W);
      for (int e = 0; e < int'(epoch_total); e++)
         descend_once(fill);
      icpt = clamp_to(sub_sat(icpt_c, mul_shift(slope_c, mean_x, 16)), COEF_W);
      f.slope = slope_c[47:0];
      f.intercept = icpt[47:0];
      f.saturated = sat_seen;
      f.dropped = drop_seen;
      return f;
   endfunction

   always @(posedge clock) begin
      fit_type f;
      int      errs;
      errs = 0;
      if (reset) begin
         slope_rate <= RATE_RESET;
         intercept_rate <= RATE_RESET;
         epoch_total <= EPOCH_RESET;
         fill = 0;
         sat_seen = 1'b0;
         drop_seen = 1'b0;
         fit_q.delete();
         fits_pending <= 0;
         fit_errors <= 0;
         fits_checked <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_SLOPE_RATE:     slope_rate <= csr_wdata;
               CSR_INTERCEPT_RATE: intercept_rate <= csr_wdata;
               CSR_EPOCH_COUNT:    epoch_total <= csr_wdata[EPOCH_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (fill < MAX_SAMPLES) begin
               x_mem[fill] = int'(req_tdata[31:0]);
               y_mem[fill] = int'(req_tdata[63:32]);
               fill++;
            end else begin
               drop_seen = 1'b1;
            end
            if (req_tlast) begin
               fit_q.push_back(fit_line());
               fill = 0;
               sat_seen = 1'b0;
               drop_seen = 1'b0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (fit_q.size() == 0) begin
               $error("response with no request waiting for one");
               errs++;
            end else begin
               f = fit_q.pop_front();
               fits_checked <= fits_checked + 1;
               if (rsp_tdata[47:0] !== f.slope) begin
                  $error("slope: expected %h, got %h", f.slope, rsp_tdata[47:0]);
                  errs++;
               end
               if (rsp_tdata[95:48] !== f.intercept) begin
                  $error("intercept: expected %h, got %h", f.intercept, rsp_tdata[95:48]);
                  errs++;
               end
               if (rsp_tuser[0] !== f.saturated) begin
                  $error("saturated: expected %b, got %b", f.saturated, rsp_tuser[0]);
                  errs++;
               end
               if (rsp_tuser[1] !== f.dropped) begin
                  $error("samples_dropped: expected %b, got %b", f.dropped, rsp_tuser[1]);
                  errs++;
               end
            end
         end
         fit_errors <= fit_errors + errs;
         fits_pending <= fit_q.size();
      end
   end

endmodule

`default_nettype wire

@@ tb/linear_regression_gradient_descent_core_tb.sv @@
// Top of the regression core testbench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps
`default_nettype none

module linear_regression_gradient_descent_core_tb;
   import lrgd_pkg::*;

   localparam int MAX_SAMPLES_FOR_TB = 1024;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int          fit_errors, fits_pending, fits_checked;
   int          requests_sent = 0;
   int          sets_sent = 0;
   logic        steady = 1'b0;
   logic        hold_go = 1'b0;
   int          hold_left = 0;
   int          stall_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   linear_regression_gradient_descent_core u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .csr_we, .csr_addr, .csr_wdata
   );

   lrgd_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .csr_we, .csr_addr, .csr_wdata,
      .fit_errors, .fits_pending, .fits_checked
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result side: random stalls, plus one long hold requested by the stimulus.
   always @(posedge clock) begin
      if (hold_go) begin
         hold_left = 2500;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   task automatic send_sample(logic [31:0] x, logic [31:0] y, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {y, x};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      if (last) sets_sent++;
   endtask

   task automatic go_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (fits_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] pick_value(bit wide);
      if (wide) return $urandom;
      return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
   endfunction

   task automatic send_set(int n, bit wide);
      for (int i = 0; i < n; i++)
         send_sample(pick_value(wide), pick_value(wide), i == n - 1);
   endtask

   function automatic logic [31:0] pick_rate();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(1, 32'h0400_0000);
      endcase
   endfunction

   initial begin
      int    phase;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // Reset epoch count would make every set far too slow, so it goes first.
      write_reg(CSR_EPOCH_COUNT, 32'd2);

      // Single sample at the field extremes, then a pair the other way round.
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_sample(32'h0, 32'h0, 1'b1);
      go_idle();
      // No epochs: slope stays zero and the intercept is the mean of y.
      write_reg(CSR_EPOCH_COUNT, 32'd0);
      send_sample(32'h0001_0000, 32'h0003_0000, 1'b0);
      send_sample(32'h0002_0000, 32'h0005_0000, 1'b0);
      send_sample(32'h0003_0000, 32'h0007_0000, 1'b1);
      go_idle();
      // Largest rates on wide data drive the coefficients into saturation.
      // The upper bits of the epoch value lie outside the register and are lost.
      write_reg(CSR_SLOPE_RATE, 32'hFFFF_FFFF);
      write_reg(CSR_INTERCEPT_RATE, 32'hFFFF_FFFF);
      write_reg(CSR_EPOCH_COUNT, 32'hFFF0_0010);
      write_reg(2'd3, 32'h1234_5678);
      send_sample(32'h7FFF_0000, 32'h8000_1000, 1'b0);
      send_sample(32'h8001_0000, 32'h7FFF_F000, 1'b0);
      send_sample(32'h4000_0000, 32'hC000_0000, 1'b0);
      send_sample(32'hC000_0000, 32'h4000_0000, 1'b1);
      go_idle();
      write_reg(CSR_SLOPE_RATE, 32'h0);
      write_reg(CSR_INTERCEPT_RATE, 32'h0010_0000);
      write_reg(CSR_EPOCH_COUNT, 32'd3);
      send_sample(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
      send_sample(32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
      go_idle();

      phase = 0;
      while (requests_sent < 1650) begin
         phase++;
         write_reg(CSR_SLOPE_RATE, pick_rate());
         write_reg(CSR_INTERCEPT_RATE, pick_rate());
         write_reg(CSR_EPOCH_COUNT, ($urandom_range(0, 9) == 0) ? 32'd20
                                                                  : $urandom_range(0, 4));
         steady = ($urandom_range(0, 5) == 0);
         if (phase == 6) begin
            // Overflowing set: the memory fills and the tail, final sample too, is dropped.
            write_reg(CSR_EPOCH_COUNT, 32'd1);
            send_set(MAX_SAMPLES_FOR_TB + 6, $urandom_range(0, 1));
         end else if (phase == 10) begin
            // Long output hold: one response parks, the next set must stall the input.
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
            for (int s = 0; s < 4; s++) send_set($urandom_range(2, 6), 1'b0);
         end else if (phase == 14) begin
            write_reg(CSR_SLOPE_RATE, 32'h0080_0000);
            write_reg(CSR_INTERCEPT_RATE, 32'h0100_0000);
            write_reg(CSR_EPOCH_COUNT, 32'd200);
            send_set(6, 1'b0);
         end else begin
            repeat ($urandom_range(1, 6))
               send_set($urandom_range(1, 8), $urandom_range(0, 2) == 0);
         end
         steady = 1'b0;
         go_idle();
      end

      repeat (200) @(posedge clock);
      $display("Sent %0d requests in %0d data sets; %0d fits checked.",
               requests_sent, sets_sent, fits_checked);
      $display("Covered extremes, zero epochs, saturation, a dropped tail and a long stall.");
      if (fit_errors == 0 && fits_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
sv/lrgd_pkg.sv
sv/linear_regression_gradient_descent_core.sv
tb/lrgd_checker.sv
tb/linear_regression_gradient_descent_core_tb.sv
